### hw/rtl/spq_pkg.sv
// Shared types and request codes for the stable priority queue.
`default_nettype none

package spq_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] prio;
    logic [31:0]        payload;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/stable_priority_queue.sv
// Stable priority queue top level: a row of DEPTH sorted cells and a result register.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while in_stall is low; every cell compares and shifts in the same cycle.
// in_stall rises only while a finished result waits on out_stall.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
`default_nettype none

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_priority_req,
  input  wire logic [31:0] in_payload,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_payload,
  output logic [15:0]      out_priority,
  output logic             out_entry_valid,
  output logic             out_rejected
);

  entry_t     cells[DEPTH];
  logic       keeps[DEPTH];
  entry_t     new_entry;
  entry_t     empty_entry;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;
  entry_t     head;
  req_t       req;

  logic        out_valid_r;
  logic [31:0] out_payload_r;
  logic [15:0] out_priority_r;
  logic        out_entry_valid_r;
  logic        out_rejected_r;
  logic [31:0] out_payload_nxt;
  logic [15:0] out_priority_nxt;
  logic        out_entry_valid_nxt;
  logic        out_rejected_nxt;

  assign in_stall    = out_valid_r && out_stall;
  assign accept      = in_valid && !in_stall;
  assign req         = req_t'(in_req_type);
  assign full        = cells[DEPTH-1].valid;
  assign head        = cells[0];
  assign new_entry   = '{valid: 1'b1, prio: $signed(in_priority_req), payload: in_payload};
  assign empty_entry = '{valid: 1'b0, prio: 16'sd0, payload: 32'd0};

  assign ctrl.enq = accept && (req == REQ_ENQ) && !full;
  assign ctrl.deq = accept && (req == REQ_DEQ) && head.valid;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_entry   (new_entry),
        .left_entry  (empty_entry),
        .left_keep   (1'b1),
        .right_entry (cells[1]),
        .cur_entry   (cells[0]),
        .keep        (keeps[0])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_entry   (new_entry),
        .left_entry  (cells[i-1]),
        .left_keep   (keeps[i-1]),
        .right_entry (empty_entry),
        .cur_entry   (cells[i]),
        .keep        (keeps[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_entry   (new_entry),
        .left_entry  (cells[i-1]),
        .left_keep   (keeps[i-1]),
        .right_entry (cells[i+1]),
        .cur_entry   (cells[i]),
        .keep        (keeps[i])
      );
    end
  end

  always_comb begin
    out_payload_nxt     = 32'd0;
    out_priority_nxt    = 16'd0;
    out_entry_valid_nxt = 1'b0;
    out_rejected_nxt    = 1'b0;
    case (req)
      REQ_ENQ: begin
        out_rejected_nxt = full;
      end
      REQ_DEQ, REQ_PEEK: begin
        if (head.valid) begin
          out_payload_nxt     = head.payload;
          out_priority_nxt    = head.prio;
          out_entry_valid_nxt = 1'b1;
        end
      end
      default: begin
        out_rejected_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result while it is stalled; load only on an accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_payload_r     <= out_payload_nxt;
      out_priority_r    <= out_priority_nxt;
      out_entry_valid_r <= out_entry_valid_nxt;
      out_rejected_r    <= out_rejected_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_payload     = out_payload_r;
  assign out_priority    = out_priority_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_rejected    = out_rejected_r;

endmodule

`default_nettype wire

### hw/rtl/spq_cell.sv
// One slot of the sorted row: holds an entry, inserts, shifts right or left.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     new_entry,
  input  wire entry_t     left_entry,
  input  wire logic       left_keep,
  input  wire entry_t     right_entry,
  output entry_t          cur_entry,
  output logic            keep
);

  logic               valid_r;
  logic signed [15:0] prio_r;
  logic [31:0]        payload_r;
  entry_t             cur_nxt;

  assign cur_entry = '{valid: valid_r, prio: prio_r, payload: payload_r};

  // Stay put when the stored entry is served no later than the new one.
  assign keep = valid_r && ($signed(prio_r) <= $signed(new_entry.prio));

  always_comb begin
    cur_nxt = cur_entry;
    if (ctrl.enq && !keep) begin
      cur_nxt = left_keep ? new_entry : left_entry;
    end else if (ctrl.deq) begin
      cur_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cur_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= cur_nxt.prio;
    payload_r <= cur_nxt.payload;
  end

endmodule

`default_nettype wire

### hw/rtl/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
`default_nettype none

module spq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_payload,
  input wire logic [15:0] out_priority,
  input wire logic        out_entry_valid,
  input wire logic        out_rejected
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_entry_valid && out_rejected))
    else $error("found and rejected both set");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_payload == 32'd0 && out_priority == 16'd0)
    else $error("nonzero fields without a head entry");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_payload     (out_payload),
  .out_priority    (out_priority),
  .out_entry_valid (out_entry_valid),
  .out_rejected    (out_rejected)
);

`default_nettype wire
